// ----- rtl/core/mva_pkg.sv -----
// Shared constants, types and tables of the MRU voice allocator.
`default_nettype none

package mva_pkg;

    // Sizes of the slot list and the chime set
    localparam int VOICES = 4;
    localparam int CHIMES = 8;
    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    // Field widths
    localparam int PLAYER_W   = 2;
    localparam int CHIME_IN_W = 3;
    localparam int CHIME_W    = 4;
    localparam int POLISH_W   = 3;
    localparam int MASK_W     = 4;
    localparam int STEP_W     = 10;
    localparam int BASE_W     = 10;
    localparam int PITCH_W    = 15;
    localparam int KIND_W     = 2;

    // Slot chime code for an unused slot
    localparam logic [CHIME_W-1:0] NONE_CHIME = 4'hF;

    // Choice kinds
    localparam logic [KIND_W-1:0] KIND_SAME  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STEAL = 2'd2;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_POLISH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_STEP = 1'd1;
    localparam logic [POLISH_W-1:0]  TOP_POLISH_RST = 3'd4;
    localparam logic [STEP_W-1:0]    PITCH_STEP_RST = 10'd152;

    // One request as held in the input register
    typedef struct packed {
        logic [MASK_W-1:0]     busy_mask;
        logic [POLISH_W-1:0]   polish;
        logic [CHIME_IN_W-1:0] chime_id;
    } req_t;

    // Slot choice handed from the slot list to the result register
    typedef struct packed {
        logic [PLAYER_W-1:0] voice;
        logic [KIND_W-1:0]   choice_kind;
    } pick_t;

    // Base pitch of each chime; chimes outside the set sound at zero
    function automatic logic [BASE_W-1:0] base_pitch(input logic [CHIME_IN_W-1:0] chime);
        logic [BASE_W-1:0] val;
        case (chime)
            3'd0:    val = 10'd0;
            3'd1:    val = 10'd128;
            3'd2:    val = 10'd256;
            3'd3:    val = 10'd320;
            3'd4:    val = 10'd448;
            3'd5:    val = 10'd576;
            3'd6:    val = 10'd704;
            3'd7:    val = 10'd768;
            default: val = 10'd0;
        endcase
        if (int'(chime) >= CHIMES) begin
            val = '0;
        end
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mva_slot_list.sv -----
// MRU slot list: release, slot choice and move-to-front update.
`default_nettype none

module mva_slot_list
    import mva_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  advance,
    input  wire req_t  req,
    output pick_t      pick
);

    logic [PLAYER_W-1:0] player_reg  [VOICES];
    logic [CHIME_W-1:0]  chime_reg   [VOICES];
    logic [PLAYER_W-1:0] player_next [VOICES];
    logic [CHIME_W-1:0]  chime_next  [VOICES];
    logic [CHIME_W-1:0]  chime_rel   [VOICES];

    logic              found_same;
    logic              found_free;
    logic [VIDX_W-1:0] idx_same;
    logic [VIDX_W-1:0] idx_free;
    logic [VIDX_W-1:0] pick_idx;
    logic [CHIME_W-1:0] req_chime;

    assign req_chime = CHIME_W'(req.chime_id);

    // Release slots whose player went quiet
    always_comb begin
        for (int i = 0; i < VOICES; i++) begin
            if (chime_reg[i] != NONE_CHIME && !req.busy_mask[player_reg[i]]) begin
                chime_rel[i] = NONE_CHIME;
            end else begin
                chime_rel[i] = chime_reg[i];
            end
        end
    end

    // Find the first slot with the same chime and the first free slot
    always_comb begin
        found_same = 1'b0;
        found_free = 1'b0;
        idx_same   = '0;
        idx_free   = '0;
        for (int i = 0; i < VOICES; i++) begin
            if (!found_same && chime_rel[i] == req_chime) begin
                found_same = 1'b1;
                idx_same   = VIDX_W'(i);
            end
            if (!found_free && chime_rel[i] == NONE_CHIME) begin
                found_free = 1'b1;
                idx_free   = VIDX_W'(i);
            end
        end
    end

    // Prefer same chime, then free slot, then steal the least recent slot
    always_comb begin
        if (found_same) begin
            pick_idx         = idx_same;
            pick.choice_kind = KIND_SAME;
        end else if (found_free) begin
            pick_idx         = idx_free;
            pick.choice_kind = KIND_FREE;
        end else begin
            pick_idx         = VIDX_W'(VOICES - 1);
            pick.choice_kind = KIND_STEAL;
        end
        pick.voice = player_reg[pick_idx];
    end

    // Move the chosen slot to the front and shift the ones ahead of it back
    always_comb begin
        for (int i = 0; i < VOICES; i++) begin
            if (i == 0) begin
                player_next[i] = player_reg[pick_idx];
                chime_next[i]  = req_chime;
            end else if (i <= int'(pick_idx)) begin
                player_next[i] = player_reg[i-1];
                chime_next[i]  = chime_rel[i-1];
            end else begin
                player_next[i] = player_reg[i];
                chime_next[i]  = chime_rel[i];
            end
        end
    end

    // Hold the list; update on each processed transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < VOICES; i++) begin
                player_reg[i] <= PLAYER_W'(i);
                chime_reg[i]  <= NONE_CHIME;
            end
        end else if (advance) begin
            for (int i = 0; i < VOICES; i++) begin
                player_reg[i] <= player_next[i];
                chime_reg[i]  <= chime_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mva_pitch.sv -----
// Pitch computation: base pitch of the chime minus step times polish deficit.
`default_nettype none

module mva_pitch
    import mva_pkg::*;
(
    input  wire logic [CHIME_IN_W-1:0]   chime_id,
    input  wire logic [POLISH_W-1:0]     polish,
    input  wire logic [POLISH_W-1:0]     top_polish,
    input  wire logic [STEP_W-1:0]       pitch_step,
    output logic signed [PITCH_W-1:0]    pitch
);

    logic signed [POLISH_W:0]    diff;
    logic signed [PITCH_W-1:0]   diff_ext;
    logic signed [PITCH_W-1:0]   step_ext;
    logic signed [PITCH_W-1:0]   base_ext;
    logic signed [PITCH_W-1:0]   offset;

    // Signed polish deficit, -7..7
    assign diff     = $signed({1'b0, top_polish}) - $signed({1'b0, polish});
    assign diff_ext = PITCH_W'(diff);
    assign step_ext = $signed(PITCH_W'(pitch_step));
    assign base_ext = $signed(PITCH_W'(base_pitch(chime_id)));

    // Result always fits the field, so plain wraparound arithmetic is exact
    assign offset = step_ext * diff_ext;
    assign pitch  = base_ext - offset;

endmodule

`default_nettype wire

// ----- rtl/core/mva_voice_allocator_core_placeholder_removed.sv -----
// Result register stage of the MRU voice allocator.
`default_nettype none

module mva_result_stage
    import mva_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      advance,
    input  wire logic                      m_tready,
    input  wire pick_t                     pick,
    input  wire logic signed [PITCH_W-1:0] pitch,
    output logic                           out_valid,
    output logic [PLAYER_W-1:0]            out_voice,
    output logic signed [PITCH_W-1:0]      out_pitch,
    output logic [KIND_W-1:0]              out_kind
);

    logic                       valid_reg;
    logic [PLAYER_W-1:0]        voice_reg;
    logic signed [PITCH_W-1:0]  pitch_reg;
    logic [KIND_W-1:0]          kind_reg;

    // Set on a new result, clear when the held one is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Load the payload with each new result
    always_ff @(posedge aclk) begin
        if (advance) begin
            voice_reg <= pick.voice;
            kind_reg  <= pick.choice_kind;
            pitch_reg <= pitch;
        end
    end

    assign out_valid = valid_reg;
    assign out_voice = voice_reg;
    assign out_pitch = pitch_reg;
    assign out_kind  = kind_reg;

endmodule

`default_nettype wire

// ----- rtl/core/mru_voice_allocator_core.sv -----
// Top level of the MRU voice allocator: stream ports, input register, configuration.
//
// Each request is registered in the input register on acceptance; the slot list then picks
// a slot and moves it to the front while the result register loads, so a result passes
// through the input register and the result register before it can be taken; one request
// is accepted per cycle while the result side does not stall. The rate holds because the
// slot list is updated in the same cycle as the result register loads, ready for the next
// request. The result register decouples the sides, so the input register can still take
// a request while one result waits. Registers: index 0 top_polish (reset 4),
// index 1 pitch_step (reset 152); they are to be written only while no request is in
// flight.
`default_nettype none

module mru_voice_allocator_core
    import mva_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Request stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [2:0] chime_id, [5:3] polish,
                                                  // [9:6] busy_mask, [15:10] zero
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata,   // [1:0] voice, [16:2] pitch,
                                                  // [23:17] zero
    output logic [KIND_W-1:0]          m_tuser,   // [1:0] choice_kind
    // Configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic                      in_valid_reg;
    req_t                      req_reg;
    logic [POLISH_W-1:0]       top_polish_reg;
    logic [STEP_W-1:0]         pitch_step_reg;
    logic                      advance;
    pick_t                     pick;
    logic signed [PITCH_W-1:0] pitch;
    logic                      out_valid;
    logic [PLAYER_W-1:0]       out_voice;
    logic signed [PITCH_W-1:0] out_pitch;
    logic [KIND_W-1:0]         out_kind;

    // Process the held request when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_polish_reg <= TOP_POLISH_RST;
            pitch_step_reg <= PITCH_STEP_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TOP_POLISH: top_polish_reg <= cfg_wdata[POLISH_W-1:0];
                REG_PITCH_STEP: pitch_step_reg <= cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Capture the request payload on each transaction
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg.chime_id  <= s_tdata[2:0];
            req_reg.polish    <= s_tdata[5:3];
            req_reg.busy_mask <= s_tdata[9:6];
        end
    end

    mva_slot_list u_slot_list (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .req     (req_reg),
        .pick    (pick)
    );

    mva_pitch u_pitch (
        .chime_id   (req_reg.chime_id),
        .polish     (req_reg.polish),
        .top_polish (top_polish_reg),
        .pitch_step (pitch_step_reg),
        .pitch      (pitch)
    );

    mva_result_stage u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .m_tready  (m_tready),
        .pick      (pick),
        .pitch     (pitch),
        .out_valid (out_valid),
        .out_voice (out_voice),
        .out_pitch (out_pitch),
        .out_kind  (out_kind)
    );

    // Drive the result stream
    assign m_tvalid = out_valid;
    assign m_tdata  = {7'd0, out_pitch, out_voice};
    assign m_tuser  = out_kind;

    // A stalled input side means both stages are full and the output is blocked
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid && !m_tready))
        else $error("input stalled while a stage was free");

    // A processed request shows up as a result with its chosen slot
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (out_valid && out_voice == $past(pick.voice)
                     && out_kind == $past(pick.choice_kind)))
        else $error("processed request did not reach the result register");

    // Results carry only defined choice kinds
    a_kind_defined: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_SAME || m_tuser == KIND_FREE
                      || m_tuser == KIND_STEAL))
        else $error("undefined choice kind on the result stream");

endmodule

`default_nettype wire

// ----- dv/mru_voice_allocator_core_test.sv -----
// Self-checking testbench for the MRU voice allocator core with a built-in slot-list predictor.
`default_nettype none

module mru_voice_allocator_core_test;
    import mva_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One predicted or observed grant
    typedef struct packed {
        logic [PLAYER_W-1:0] voice;
        logic [PITCH_W-1:0]  pitch;
        logic [KIND_W-1:0]   kind;
    } voice_grant_t;

    // Receiver stall patterns
    typedef enum int {RX_OPEN, RX_COIN, RX_CHOKE} rx_mode_t;

    // Tracks the slot list and the registers, predicts each grant and checks results in order
    class voice_grant_board;
        logic [PLAYER_W-1:0] slot_player [VOICES];
        logic [CHIME_W-1:0]  slot_chime [VOICES];
        logic [POLISH_W-1:0] top_polish;
        logic [STEP_W-1:0]   pitch_step;
        int                  chime_base [CHIMES];
        voice_grant_t        pending_grants [$];
        int                  failures;

        function new();
            top_polish = TOP_POLISH_RST;
            pitch_step = PITCH_STEP_RST;
            chime_base = '{0, 128, 256, 320, 448, 576, 704, 768};
            failures   = 0;
            for (int i = 0; i < VOICES; i++) begin
                slot_player[i] = i[PLAYER_W-1:0];
                slot_chime[i]  = NONE_CHIME;
            end
        endfunction

        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TOP_POLISH: top_polish = data[POLISH_W-1:0];
                REG_PITCH_STEP: pitch_step = data[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        // Update the slot list for one request and queue the grant it produces
        function void note_request(logic [CHIME_IN_W-1:0] chime, logic [POLISH_W-1:0] polish,
                                   logic [MASK_W-1:0] mask);
            int           pick;
            int           base;
            int           pitch_val;
            voice_grant_t grant;
            pick       = -1;
            grant.kind = KIND_STEAL;
            // free slots whose player went quiet
            for (int i = 0; i < VOICES; i++) begin
                if (slot_chime[i] != NONE_CHIME && !mask[slot_player[i]]) begin
                    slot_chime[i] = NONE_CHIME;
                end
            end
            // prefer the same chime, then the first free slot, then the least recent one
            for (int i = 0; i < VOICES && pick < 0; i++) begin
                if (slot_chime[i] == CHIME_W'(chime)) begin
                    pick       = i;
                    grant.kind = KIND_SAME;
                end
            end
            for (int i = 0; i < VOICES && pick < 0; i++) begin
                if (slot_chime[i] == NONE_CHIME) begin
                    pick       = i;
                    grant.kind = KIND_FREE;
                end
            end
            if (pick < 0) begin
                pick = VOICES - 1;
            end
            // move the chosen slot to the front
            grant.voice = slot_player[pick];
            for (int i = pick; i > 0; i--) begin
                slot_player[i] = slot_player[i-1];
                slot_chime[i]  = slot_chime[i-1];
            end
            slot_player[0] = grant.voice;
            slot_chime[0]  = CHIME_W'(chime);
            // pitch drops by one step per polish level below the top
            base        = (int'(chime) < CHIMES) ? chime_base[chime] : 0;
            pitch_val   = base - int'(pitch_step) * (int'(top_polish) - int'(polish));
            grant.pitch = pitch_val[PITCH_W-1:0];
            pending_grants.push_back(grant);
        endfunction

        function void check_grant(voice_grant_t seen);
            voice_grant_t want;
            if (pending_grants.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("%0t: unexpected result voice %0d pitch %0d kind %0d", $time,
                             seen.voice, $signed(seen.pitch), seen.kind);
                end
                return;
            end
            want = pending_grants.pop_front();
            if (want.voice != seen.voice || want.pitch != seen.pitch
                || want.kind != seen.kind) begin
                failures++;
                if (failures <= 10) begin
                    $display("%0t: mismatch exp voice %0d pitch %0d kind %0d, got %0d %0d %0d",
                             $time, want.voice, $signed(want.pitch), want.kind,
                             seen.voice, $signed(seen.pitch), seen.kind);
                end
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;   // [2:0] chime_id, [5:3] polish, [9:6] busy_mask, [15:10] zero
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;   // [1:0] voice, [16:2] pitch, [23:17] zero
    logic [KIND_W-1:0]     m_tuser;   // [1:0] choice_kind
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    voice_grant_board board;
    int               burst_left;
    rx_mode_t         rx_mode;
    int               rx_left = 0;
    int               stall_left = 0;

    mru_voice_allocator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watch both channels: check results first, then note new requests
    always @(posedge aclk) begin
        voice_grant_t seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen.voice = m_tdata[1:0];
            seen.pitch = m_tdata[16:2];
            seen.kind  = m_tuser;
            board.check_grant(seen);
        end
        if (aresetn && s_tvalid && s_tready) begin
            board.note_request(s_tdata[2:0], s_tdata[5:3], s_tdata[9:6]);
        end
    end

    // Stall the result channel in stretches of open, coin-flip and choked patterns
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(20, 80);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN: m_tready = 1'b1;
            RX_COIN: m_tready = 1'($urandom_range(0, 1));
            default: begin
                if (stall_left > 0) begin
                    m_tready = 1'b0;
                    stall_left--;
                end else begin
                    m_tready = 1'b1;
                    if ($urandom_range(0, 3) == 0) begin
                        stall_left = $urandom_range(1, 8);
                    end
                end
            end
        endcase
    end

    // Offer one request in bursts with random gaps; return at the falling edge after acceptance
    task automatic send_request(logic [CHIME_IN_W-1:0] chime, logic [POLISH_W-1:0] polish,
                                logic [MASK_W-1:0] mask);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid = 1'b1;
        s_tdata  = {6'd0, mask, polish, chime};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(posedge aclk);
        board.apply_register(idx, data);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Drop valid and hold until every grant has come back
    task automatic drain_grants();
        s_tvalid = 1'b0;
        while (board.pending_grants.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        int                    phase_top [4];
        int                    phase_step [4];
        logic [POLISH_W-1:0]   top;
        logic [STEP_W-1:0]     step;
        logic [CHIME_IN_W-1:0] chime;
        logic [MASK_W-1:0]     mask;
        phase_top  = '{0, 7, 0, 7};
        phase_step = '{0, 1023, 1023, 0};
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_TOP_POLISH;
        cfg_wdata  = '0;
        burst_left = 0;
        board      = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Fill every free slot, steal the oldest, reuse, release all, partial masks,
        // polish at both extremes and above the top level
        send_request(3'd0, 3'd0, 4'hF);
        send_request(3'd1, 3'd7, 4'hF);
        send_request(3'd2, 3'd4, 4'hF);
        send_request(3'd3, 3'd3, 4'hF);
        send_request(3'd4, 3'd5, 4'hF);
        send_request(3'd4, 3'd2, 4'hF);
        send_request(3'd3, 3'd0, 4'hF);
        send_request(3'd5, 3'd6, 4'h0);
        send_request(3'd6, 3'd1, 4'h5);
        send_request(3'd7, 3'd7, 4'hA);
        send_request(3'd7, 3'd0, 4'hF);
        send_request(3'd0, 3'd7, 4'hF);
        send_request(3'd5, 3'd3, 4'hF);
        send_request(3'd1, 3'd1, 4'h8);
        send_request(3'd2, 3'd6, 4'h0);
        send_request(3'd6, 3'd0, 4'hF);
        drain_grants();

        // Random phases over extreme and random register settings
        for (int p = 0; p < 6; p++) begin
            if (p < 4) begin
                write_register(REG_TOP_POLISH, CFG_DATA_W'(phase_top[p]));
                write_register(REG_PITCH_STEP, CFG_DATA_W'(phase_step[p]));
            end else begin
                top  = POLISH_W'($urandom_range(0, 7));
                step = STEP_W'($urandom_range(0, 1023));
                write_register(REG_TOP_POLISH, {7'($urandom_range(0, 127)), top});
                write_register(REG_PITCH_STEP, step);
            end
            for (int n = 0; n < 65; n++) begin
                // favor a few chimes and mostly busy players so reuse and stealing happen
                chime = ($urandom_range(0, 1) == 0) ? CHIME_IN_W'($urandom_range(0, 3))
                                                     : CHIME_IN_W'($urandom_range(0, 7));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: mask = 4'hF;
                    6, 7:             mask = MASK_W'($urandom_range(0, 15));
                    8:                mask = 4'h0;
                    default:          mask = ~(4'b0001 << $urandom_range(0, 3));
                endcase
                send_request(chime, POLISH_W'($urandom_range(0, 7)), mask);
            end
            drain_grants();
        end

        repeat (10) @(posedge aclk);
        if (board.failures == 0 && board.pending_grants.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // End a hung run
    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/mva_pkg.sv
rtl/core/mva_slot_list.sv
rtl/core/mva_pitch.sv
rtl/core/mva_voice_allocator_core_placeholder_removed.sv
rtl/core/mru_voice_allocator_core.sv
dv/mru_voice_allocator_core_test.sv
